// ----- rtl/fhn_pkg.sv -----
// shared constants, types and the saturation helper for the fitzhugh-nagumo update block
// no dependencies

package fhn_pkg;

    localparam int FX_W         = 32;
    localparam int FRAC_BITS    = 24;
    localparam int IDX_W        = 10;
    localparam int NEURON_COUNT = 1024;
    localparam int ADDR_W       = $clog2(NEURON_COUNT);
    localparam int MAX_SUBSTEPS = 256;
    localparam int SUBSTEPS_W   = 9;
    localparam int STEP_W       = 25;
    localparam int CNT_W        = $clog2(MAX_SUBSTEPS + 1);
    localparam int OP_W         = FX_W + 1;
    localparam int PROD_W       = 2 * OP_W;
    localparam int WIDE_W       = PROD_W - FRAC_BITS + 1;
    localparam int STORE_W      = 2 * FX_W;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [FX_W-1:0]   FX_ONE   = FX_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [FX_W-1:0]   FX_THIRD = FX_W'(((64'sd1 <<< FRAC_BITS) + 1) / 3);
    localparam logic signed [PROD_W-1:0] FX_HALF  = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = (WIDE_W'(1) <<< (FX_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -(WIDE_W'(1) <<< (FX_W - 1));

    localparam logic signed [FX_W-1:0]       COEF_A_RST   = 32'sd11744051;
    localparam logic signed [FX_W-1:0]       COEF_B_RST   = 32'sd13421773;
    localparam logic signed [FX_W-1:0]       COEF_PHI_RST = 32'sd1342177;
    localparam logic [SUBSTEPS_W-1:0]        SUBSTEPS_RST = 9'd1;
    localparam logic [STEP_W-1:0]            STEP_RST     = 25'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A    = 3'd0,
        REG_COEF_B    = 3'd1,
        REG_COEF_PHI  = 3'd2,
        REG_SUBSTEPS  = 3'd3,
        REG_STEP_SIZE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [FX_W-1:0]  coef_a;
        logic signed [FX_W-1:0]  coef_b;
        logic signed [FX_W-1:0]  coef_phi;
        logic [SUBSTEPS_W-1:0]   substeps;
        logic [STEP_W-1:0]       step_size;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic ack;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [WIDE_W-1:0] v);
        logic signed [FX_W-1:0] r;
        if (v > WIDE_MAX)
            r = WIDE_MAX[FX_W-1:0];
        else if (v < WIDE_MIN)
            r = WIDE_MIN[FX_W-1:0];
        else
            r = v[FX_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/fhn_if.sv -----
// valid/ready channel interfaces: input words, result words and register writes
// depends on fhn_pkg

interface fhn_in_if;
    logic                            valid;
    logic                            ready;
    logic [fhn_pkg::IDX_W-1:0]       neuron_index;
    logic signed [fhn_pkg::FX_W-1:0] input_current;
    logic                            disabled;

    modport source (output valid, neuron_index, input_current, disabled, input ready);
    modport sink   (input valid, neuron_index, input_current, disabled, output ready);
endinterface

interface fhn_out_if;
    logic                            valid;
    logic                            ready;
    logic [fhn_pkg::IDX_W-1:0]       out_index;
    logic                            fired;
    logic signed [fhn_pkg::FX_W-1:0] membrane_value;
    logic signed [fhn_pkg::FX_W-1:0] recovery_value;

    modport source (output valid, out_index, fired, membrane_value, recovery_value,
                    input ready);
    modport sink   (input valid, out_index, fired, membrane_value, recovery_value,
                    output ready);
endinterface

interface fhn_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fhn_pkg::CFG_IDX_W-1:0] index;
    logic [fhn_pkg::FX_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/fhn_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module fhn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/fhn_cfg_regs.sv -----
// model coefficient and substep registers behind the register write channel
// depends on fhn_pkg and fhn_if

module fhn_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    fhn_cfg_if.sink        cfg,
    output fhn_pkg::cfg_t  regs
);

    fhn_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.coef_a    <= fhn_pkg::COEF_A_RST;
            regs_reg.coef_b    <= fhn_pkg::COEF_B_RST;
            regs_reg.coef_phi  <= fhn_pkg::COEF_PHI_RST;
            regs_reg.substeps  <= fhn_pkg::SUBSTEPS_RST;
            regs_reg.step_size <= fhn_pkg::STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                fhn_pkg::REG_COEF_A:    regs_reg.coef_a    <= cfg.data;
                fhn_pkg::REG_COEF_B:    regs_reg.coef_b    <= cfg.data;
                fhn_pkg::REG_COEF_PHI:  regs_reg.coef_phi  <= cfg.data;
                fhn_pkg::REG_SUBSTEPS:  regs_reg.substeps  <= cfg.data[fhn_pkg::SUBSTEPS_W-1:0];
                fhn_pkg::REG_STEP_SIZE: regs_reg.step_size <= cfg.data[fhn_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/fhn_euler_core.sv -----
// euler substep sequencer around one shared saturating q8.24 multiplier
// depends on fhn_pkg

module fhn_euler_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fhn_pkg::cfg_t                   cfg,
    input  fhn_pkg::core_ctrl_t             ctrl,
    input  logic signed [fhn_pkg::FX_W-1:0] x_in,
    input  logic signed [fhn_pkg::FX_W-1:0] w_in,
    input  logic signed [fhn_pkg::FX_W-1:0] cur_in,
    output fhn_pkg::core_stat_t             stat,
    output logic signed [fhn_pkg::FX_W-1:0] x_out,
    output logic signed [fhn_pkg::FX_W-1:0] w_out,
    output logic                            fired
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} state_t;

    // each phase issues one product; every phase but PH_SQ takes in the one issued the phase before
    typedef enum logic [2:0] {
        PH_SQ  = 3'd0,
        PH_BW  = 3'd1,
        PH_CU  = 3'd2,
        PH_DW  = 3'd3,
        PH_C   = 3'd4,
        PH_DWS = 3'd5,
        PH_DXS = 3'd6,
        PH_X   = 3'd7
    } phase_t;

    state_t                              state_reg;
    phase_t                              phase_reg;
    logic                                final_reg;
    logic [fhn_pkg::CNT_W-1:0]           cnt_reg;
    logic signed [fhn_pkg::FX_W-1:0]     x_reg;
    logic signed [fhn_pkg::FX_W-1:0]     w_reg;
    logic signed [fhn_pkg::FX_W-1:0]     cur_reg;
    logic signed [fhn_pkg::FX_W-1:0]     sq_reg;
    logic signed [fhn_pkg::FX_W-1:0]     t_reg;
    logic signed [fhn_pkg::FX_W-1:0]     cu_reg;
    logic signed [fhn_pkg::FX_W-1:0]     dw_reg;
    logic signed [fhn_pkg::FX_W-1:0]     dx_reg;
    logic                                fired_reg;
    logic signed [fhn_pkg::PROD_W-1:0]   prod_reg;

    logic signed [fhn_pkg::FX_W-1:0]     coef_a;
    logic signed [fhn_pkg::FX_W-1:0]     coef_b;
    logic signed [fhn_pkg::FX_W-1:0]     coef_phi;
    logic signed [fhn_pkg::OP_W-1:0]     step_op;
    logic signed [fhn_pkg::OP_W-1:0]     op_a;
    logic signed [fhn_pkg::OP_W-1:0]     op_b;
    logic signed [fhn_pkg::PROD_W-1:0]   prod_sh;
    logic signed [fhn_pkg::FX_W-1:0]     mres;
    logic signed [fhn_pkg::FX_W-1:0]     edge_val;
    logic [fhn_pkg::CNT_W-1:0]           n_clamp;

    assign coef_a   = cfg.coef_a;
    assign coef_b   = cfg.coef_b;
    assign coef_phi = cfg.coef_phi;
    assign step_op  = fhn_pkg::OP_W'($signed({1'b0, cfg.step_size}));

    assign n_clamp = (32'(cfg.substeps) > fhn_pkg::MAX_SUBSTEPS)
                   ? fhn_pkg::CNT_W'(fhn_pkg::MAX_SUBSTEPS)
                   : fhn_pkg::CNT_W'(cfg.substeps);

    // round to nearest, ties up, then saturate
    assign prod_sh = (prod_reg + fhn_pkg::FX_HALF) >>> fhn_pkg::FRAC_BITS;
    assign mres    = fhn_pkg::sat_fx(prod_sh[fhn_pkg::WIDE_W-1:0]);

    assign edge_val = fhn_pkg::sat_fx(fhn_pkg::WIDE_W'(x_reg) - fhn_pkg::WIDE_W'(mres));

    always_comb
    begin
        unique case (phase_reg)
            PH_SQ:
            begin
                op_a = fhn_pkg::OP_W'(x_reg);
                op_b = fhn_pkg::OP_W'(x_reg);
            end
            PH_BW:
            begin
                op_a = fhn_pkg::OP_W'(coef_b);
                op_b = fhn_pkg::OP_W'(w_reg);
            end
            PH_CU:
            begin
                op_a = fhn_pkg::OP_W'(sq_reg);
                op_b = fhn_pkg::OP_W'(x_reg);
            end
            PH_DW:
            begin
                op_a = fhn_pkg::OP_W'(coef_phi);
                op_b = fhn_pkg::OP_W'(t_reg);
            end
            PH_C:
            begin
                op_a = fhn_pkg::OP_W'(cu_reg);
                op_b = fhn_pkg::OP_W'(fhn_pkg::FX_THIRD);
            end
            PH_DWS:
            begin
                op_a = fhn_pkg::OP_W'(dw_reg);
                op_b = step_op;
            end
            PH_DXS:
            begin
                op_a = fhn_pkg::OP_W'(dx_reg);
                op_b = step_op;
            end
            PH_X:
            begin
                op_a = fhn_pkg::OP_W'(x_reg);
                op_b = fhn_pkg::OP_W'(x_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            phase_reg <= PH_SQ;
            final_reg <= 1'b0;
            cnt_reg   <= '0;
            x_reg     <= '0;
            w_reg     <= '0;
            cur_reg   <= '0;
            sq_reg    <= '0;
            t_reg     <= '0;
            cu_reg    <= '0;
            dw_reg    <= '0;
            dx_reg    <= '0;
            fired_reg <= 1'b0;
            prod_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        x_reg     <= x_in;
                        w_reg     <= w_in;
                        cur_reg   <= cur_in;
                        cnt_reg   <= n_clamp;
                        final_reg <= (n_clamp == '0);
                        phase_reg <= PH_SQ;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    prod_reg  <= op_a * op_b;
                    phase_reg <= phase_t'(phase_reg + 3'd1);
                    unique case (phase_reg)
                        PH_BW:
                        begin
                            sq_reg <= mres;
                        end
                        PH_CU:
                        begin
                            t_reg <= fhn_pkg::sat_fx(fhn_pkg::WIDE_W'(x_reg)
                                                     + fhn_pkg::WIDE_W'(coef_a)
                                                     - fhn_pkg::WIDE_W'(mres));
                        end
                        PH_DW:
                        begin
                            cu_reg <= mres;
                        end
                        PH_C:
                        begin
                            dw_reg <= mres;
                        end
                        PH_DWS:
                        begin
                            dx_reg <= fhn_pkg::sat_fx(fhn_pkg::WIDE_W'(x_reg)
                                                      - fhn_pkg::WIDE_W'(mres)
                                                      - fhn_pkg::WIDE_W'(w_reg)
                                                      + fhn_pkg::WIDE_W'(cur_reg));
                            if (final_reg)
                            begin
                                fired_reg <= (w_reg > edge_val) && (x_reg > fhn_pkg::FX_ONE);
                                state_reg <= C_DONE;
                            end
                        end
                        PH_DXS:
                        begin
                            w_reg <= fhn_pkg::sat_fx(fhn_pkg::WIDE_W'(w_reg)
                                                     + fhn_pkg::WIDE_W'(mres));
                        end
                        PH_X:
                        begin
                            x_reg   <= fhn_pkg::sat_fx(fhn_pkg::WIDE_W'(x_reg)
                                                       + fhn_pkg::WIDE_W'(mres));
                            cnt_reg <= cnt_reg - fhn_pkg::CNT_W'(1);
                            if (cnt_reg == fhn_pkg::CNT_W'(1))
                            begin
                                final_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                C_DONE:
                begin
                    if (ctrl.ack)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_DONE);
    assign x_out     = x_reg;
    assign w_out     = w_reg;
    assign fired     = fired_reg;

endmodule

// ----- rtl/fitzhugh_nagumo_neuron_update.sv -----
// FitzHugh-Nagumo neuron update, Q8.24 fixed point. Membrane and recovery values of all
// 1024 neurons sit in one 64-bit wide RAM that is zeroed by a clearing pass after reset,
// during which no input word is taken (register writes are taken at any time).
// An enabled word reads its neuron, runs the configured number of Euler substeps (capped
// at 256) on one shared multiplier, writes the neuron back and presents one result word;
// a disabled word is taken and dropped. One word is worked on at a time: an update runs
// the eight multiplier passes of each substep and a final spike test, besides taking the
// word, the RAM read and the write-back. The result register lets the next word be taken
// while a result still waits on the output.
// Depends on fhn_pkg, fhn_if, fhn_ram, fhn_cfg_regs and fhn_euler_core.

module fitzhugh_nagumo_neuron_update (
    input  logic        clk,
    input  logic        rst_n,
    fhn_cfg_if.sink     cfg,
    fhn_in_if.sink      items,
    fhn_out_if.source   results
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOAD, S_RUN} state_t;

    state_t                              state_reg;
    logic [fhn_pkg::ADDR_W-1:0]          clr_addr_reg;
    logic [fhn_pkg::IDX_W-1:0]           idx_reg;
    logic signed [fhn_pkg::FX_W-1:0]     cur_reg;
    logic                                out_valid_reg;
    logic [fhn_pkg::IDX_W-1:0]           out_index_reg;
    logic                                out_fired_reg;
    logic signed [fhn_pkg::FX_W-1:0]     out_x_reg;
    logic signed [fhn_pkg::FX_W-1:0]     out_w_reg;

    fhn_pkg::cfg_t                       regs;
    fhn_pkg::core_ctrl_t                 core_ctrl;
    fhn_pkg::core_stat_t                 core_stat;
    logic signed [fhn_pkg::FX_W-1:0]     core_x;
    logic signed [fhn_pkg::FX_W-1:0]     core_w;
    logic                                core_fired;

    logic                                accept;
    logic                                in_range;
    logic                                take;
    logic                                out_free;
    logic                                finish;
    logic                                ram_we;
    logic [fhn_pkg::ADDR_W-1:0]          ram_waddr;
    logic [fhn_pkg::STORE_W-1:0]         ram_wdata;
    logic [fhn_pkg::STORE_W-1:0]         ram_rdata;

    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;
    assign in_range    = (32'(items.neuron_index) < fhn_pkg::NEURON_COUNT);
    assign take        = accept && !items.disabled && in_range;
    assign out_free    = !out_valid_reg || results.ready;
    assign finish      = (state_reg == S_RUN) && core_stat.done && out_free;

    assign core_ctrl.start = (state_reg == S_LOAD);
    assign core_ctrl.ack   = finish;

    assign ram_we    = (state_reg == S_CLEAR) || finish;
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg
                                              : idx_reg[fhn_pkg::ADDR_W-1:0];
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : {core_x, core_w};

    fhn_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    fhn_ram #(
        .WIDTH (fhn_pkg::STORE_W),
        .DEPTH (fhn_pkg::NEURON_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (take),
        .raddr (items.neuron_index[fhn_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    fhn_euler_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (regs),
        .ctrl   (core_ctrl),
        .x_in   (ram_rdata[fhn_pkg::STORE_W-1:fhn_pkg::FX_W]),
        .w_in   (ram_rdata[fhn_pkg::FX_W-1:0]),
        .cur_in (cur_reg),
        .stat   (core_stat),
        .x_out  (core_x),
        .w_out  (core_w),
        .fired  (core_fired)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_fired_reg <= 1'b0;
            out_x_reg     <= '0;
            out_w_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + fhn_pkg::ADDR_W'(1);
                    if (clr_addr_reg == fhn_pkg::ADDR_W'(fhn_pkg::NEURON_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        idx_reg   <= items.neuron_index;
                        cur_reg   <= items.input_current;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            priority if (finish)
            begin
                out_valid_reg <= 1'b1;
                out_index_reg <= idx_reg;
                out_fired_reg <= core_fired;
                out_x_reg     <= core_x;
                out_w_reg     <= core_w;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.out_index      = out_index_reg;
    assign results.fired          = out_fired_reg;
    assign results.membrane_value = out_x_reg;
    assign results.recovery_value = out_w_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.start |-> !core_stat.busy)
        else $error("core started while busy");

    a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !core_stat.busy)
        else $error("input open while core busy");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> results.valid && (results.membrane_value == $past(core_x))
                   && (results.out_index == $past(idx_reg)))
        else $error("result word not loaded on finish");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !results.valid && !core_stat.busy)
        else $error("activity during clearing pass");
`endif

endmodule
